>>> rtl/ir_joystick_frame_encoder_unit_defines.svh
// assertion macros for the ir joystick frame encoder
`ifndef IR_JOYSTICK_FRAME_ENCODER_UNIT_DEFINES_SVH
`define IR_JOYSTICK_FRAME_ENCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define IRJFE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("irjfe same-cycle check failed");
// next-cycle implication
`define IRJFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("irjfe next-cycle check failed");
`else
`define IRJFE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define IRJFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/irjfe_pkg.sv
// shared constants, types and microcode rom of the ir joystick frame encoder
package irjfe_pkg;

   localparam int DATA_BITS = 12;
   localparam int FRAME_W   = 2 * DATA_BITS;
   localparam int CNT_W     = (FRAME_W > 1) ? $clog2(FRAME_W) : 1;

   localparam int LEN_W     = 8;
   localparam int NUM_REGS  = 7;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HDR_MARK   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HDR_SPACE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_MARK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ZERO_SPACE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MARK   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_SPACE  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LIMIT = 3'd6;

   localparam logic [LEN_W-1:0] CFG_RESET [NUM_REGS] =
      '{8'd44, 8'd15, 8'd6, 8'd29, 8'd20, 8'd15, 8'd4};

   // program steps
   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] STEP_WAIT   = 2'd0;
   localparam logic [STEP_W-1:0] STEP_HEADER = 2'd1;
   localparam logic [STEP_W-1:0] STEP_ID     = 2'd2;
   localparam logic [STEP_W-1:0] STEP_BITS   = 2'd3;

   // pair source select
   localparam int SEL_W = 2;
   localparam logic [SEL_W-1:0] SEL_HEADER = 2'd0;
   localparam logic [SEL_W-1:0] SEL_ZERO   = 2'd1;
   localparam logic [SEL_W-1:0] SEL_SHIFT  = 2'd2;

   typedef struct packed {
      logic              wait_req;
      logic              emit;
      logic              loop;
      logic              load_cnt;
      logic [SEL_W-1:0]  sel;
      logic [STEP_W-1:0] next_step;
   } ucode_type;

   typedef struct packed {
      logic             req_ready;
      logic             emit;
      logic             last;
      logic [SEL_W-1:0] sel;
   } seq_ctrl_type;

   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      unique case (step)
         STEP_WAIT: begin
            w.wait_req  = 1'b1;
            w.next_step = STEP_HEADER;
         end
         STEP_HEADER: begin
            w.emit      = 1'b1;
            w.sel       = SEL_HEADER;
            w.next_step = STEP_ID;
         end
         STEP_ID: begin
            w.emit      = 1'b1;
            w.load_cnt  = 1'b1;
            w.sel       = SEL_ZERO;
            w.next_step = STEP_BITS;
         end
         STEP_BITS: begin
            w.emit      = 1'b1;
            w.loop      = 1'b1;
            w.sel       = SEL_SHIFT;
            w.next_step = STEP_WAIT;
         end
         default: begin
            w.next_step = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

>>> rtl/irjfe_sequencer.sv
// microcoded step sequencer: step counter, rom word, bit loop counter
module irjfe_sequencer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_fire,
   input  logic                    send,
   input  logic                    slot_free,
   output irjfe_pkg::seq_ctrl_type ctrl
);
   import irjfe_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   ucode_type         word;
   logic              fire;
   logic              cnt_zero;

   assign word     = ucode(step_ff);
   assign fire     = word.emit && slot_free;
   assign cnt_zero = (cnt_ff == '0);

   always_comb begin
      step_in = step_ff;
      cnt_in  = cnt_ff;
      if (word.wait_req) begin
         if (req_fire && send) step_in = word.next_step;
      end else if (fire) begin
         if (word.load_cnt) cnt_in = CNT_W'(FRAME_W - 1);
         if (word.loop && !cnt_zero) begin
            cnt_in = cnt_ff - 1'b1;
         end else begin
            step_in = word.next_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_WAIT;
         cnt_ff  <= '0;
      end else begin
         step_ff <= step_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign ctrl.req_ready = word.wait_req;
   assign ctrl.emit      = word.emit;
   assign ctrl.last      = word.loop && cnt_zero;
   assign ctrl.sel       = word.sel;

endmodule

>>> rtl/ir_joystick_frame_encoder_unit.sv
// top level of the ir joystick frame encoder: config registers, datapath, output register
//
//  channel  dir  handshake             payload
//  req      in   req_valid/req_ready   req_joystick_bits[11:0]
//  rsp      out  rsp_valid/rsp_ready   rsp_mark_length, rsp_space_length, rsp_frame_end
//  csr      in   csr_valid/csr_ready   csr_index[2:0], csr_data[7:0]
//
//  a tick is taken in the wait step; a sent frame then puts out
//  26 pair beats, one a cycle while rsp_ready stays high
//  a suppressed (idle) tick produces no beat
//  the pace is set by the single output register: one pair per rom step fire
//  reset loads the register defaults, clears the idle count and the sequencer
//  rsp stalls freeze the sequencer in place; csr is always ready
`include "ir_joystick_frame_encoder_unit_defines.svh"

module ir_joystick_frame_encoder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [irjfe_pkg::DATA_BITS-1:0]      req_joystick_bits,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [irjfe_pkg::LEN_W-1:0]          rsp_mark_length,
   output logic [irjfe_pkg::LEN_W-1:0]          rsp_space_length,
   output logic                                 rsp_frame_end,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [irjfe_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [irjfe_pkg::LEN_W-1:0]          csr_data
);
   import irjfe_pkg::*;

   // configuration registers
   logic [LEN_W-1:0] cfg_ff [NUM_REGS];

   // frame state
   logic [LEN_W-1:0]   idle_ff, idle_in;
   logic [FRAME_W-1:0] shift_ff;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] mark_ff, space_ff;
   logic             end_ff;

   seq_ctrl_type     ctrl;
   logic             req_fire;
   logic             send;
   logic             slot_free;
   logic             load_out;
   logic [LEN_W-1:0] limit;
   logic [LEN_W-1:0] sel_mark, sel_space;

   assign csr_ready = 1'b1;
   assign req_ready = ctrl.req_ready;
   assign req_fire  = req_valid && ctrl.req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign load_out  = ctrl.emit && slot_free;
   assign limit     = cfg_ff[REG_IDLE_LIMIT];

   // writes beyond the register list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) cfg_ff[i] <= CFG_RESET[i];
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // idle count saturates at the limit; a lowered limit pulls it down on an idle tick
   always_comb begin
      if (req_joystick_bits != '0) begin
         idle_in = '0;
      end else if (idle_ff < limit) begin
         idle_in = idle_ff + 1'b1;
      end else begin
         idle_in = limit;
      end
   end
   assign send = (idle_in < limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff <= '0;
      end else if (req_fire) begin
         idle_ff <= idle_in;
      end
   end

   // data bits then inverted check bits, msb out first
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
      end else if (req_fire && send) begin
         shift_ff <= {req_joystick_bits, ~req_joystick_bits};
      end else if (load_out && (ctrl.sel == SEL_SHIFT)) begin
         shift_ff <= {shift_ff[FRAME_W-2:0], 1'b0};
      end
   end

   irjfe_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .send      (send),
      .slot_free (slot_free),
      .ctrl      (ctrl)
   );

   // pair source mux
   always_comb begin
      case (ctrl.sel)
         SEL_HEADER: begin
            sel_mark  = cfg_ff[REG_HDR_MARK];
            sel_space = cfg_ff[REG_HDR_SPACE];
         end
         SEL_SHIFT: begin
            if (shift_ff[FRAME_W-1]) begin
               sel_mark  = cfg_ff[REG_ONE_MARK];
               sel_space = cfg_ff[REG_ONE_SPACE];
            end else begin
               sel_mark  = cfg_ff[REG_ZERO_MARK];
               sel_space = cfg_ff[REG_ZERO_SPACE];
            end
         end
         default: begin
            sel_mark  = cfg_ff[REG_ZERO_MARK];
            sel_space = cfg_ff[REG_ZERO_SPACE];
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // a zero mark is sent as the shortest legal mark
   always_ff @(posedge clock) begin
      if (load_out) begin
         mark_ff  <= (sel_mark == '0) ? LEN_W'(1) : sel_mark;
         space_ff <= sel_space;
         end_ff   <= ctrl.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mark_length  = mark_ff;
   assign rsp_space_length = space_ff;
   assign rsp_frame_end    = end_ff;

   // after the last pair is loaded the program is back at the wait step
   `IRJFE_ASSERT_NEXT(a_last_returns_to_wait, clock, reset, load_out && ctrl.last, ctrl.req_ready)
   // a frame's last beat is followed by nothing or by the next frame's header
   `IRJFE_ASSERT_NEXT(a_end_drains, clock, reset, rsp_valid && rsp_ready && rsp_frame_end, !rsp_valid || !rsp_frame_end)
   // the sequencer never emits while it is waiting for a tick
   `IRJFE_ASSERT_IMPLIES(a_no_emit_in_wait, clock, reset, ctrl.req_ready, !load_out)

endmodule

>>> dv/tb_top.sv
// testbench for the ir joystick frame encoder: directed and random ticks checked per pulse beat
`timescale 1ns / 1ps

module tb_top;
   import irjfe_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   // a sent frame takes longer under rsp stalls than a suppressed tick
   localparam int SETTLE_CYCLES  = 32;
   // random ticks after the directed rows, about 150 ticks in all
   localparam int RAND_TICKS     = 125;
   localparam int N_STIM         = 42;

   // index past the end of the register file, writes to it must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_PAST_END = 3'd7;

   typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_type;

   typedef struct packed {
      logic [LEN_W-1:0] mark;
      logic [LEN_W-1:0] space;
      logic             last;
   } pulse_pair_type;

   // pinned rows carry the frame/no-frame outcome and the header pair typed in
   typedef struct packed {
      row_kind_type         kind;
      logic [DATA_BITS-1:0] bits;
      logic [CSR_IDX_W-1:0] idx;
      logic [LEN_W-1:0]     val;
      logic                 pinned;
      logic                 sent;
      logic [LEN_W-1:0]     hdr_mark;
      logic [LEN_W-1:0]     hdr_space;
   } stim_row_type;

   localparam stim_row_type STIM_ROWS [N_STIM] = '{
      // defaults after reset, all-zero and all-one data
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b1, 1'b1, 8'd44,  8'd15},
      '{ROW_TICK,  12'hFFF, REG_HDR_MARK,   8'd0,   1'b1, 1'b1, 8'd44,  8'd15},
      '{ROW_TICK,  12'h001, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h800, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'hA5A, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h5A5, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      // idle run up to the default limit of four, then saturated
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b1, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b1, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h001, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      // idle count at three, then the limit drops below it
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_IDLE_LIMIT, 8'd1,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b1, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h010, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      // zero limit: nothing goes out, even for nonzero data
      '{ROW_WRITE, 12'h000, REG_IDLE_LIMIT, 8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'hFFF, REG_HDR_MARK,   8'd0,   1'b1, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b1, 1'b0, 8'd0,   8'd0},
      // zero marks are sent as one, low and high space extremes
      '{ROW_WRITE, 12'h000, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_HDR_SPACE,  8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_ZERO_MARK,  8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_ZERO_SPACE, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_ONE_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_ONE_SPACE,  8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_IDLE_LIMIT, 8'd255, 1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'hF0F, REG_HDR_MARK,   8'd0,   1'b1, 1'b1, 8'd1,   8'd0},
      '{ROW_TICK,  12'h0F0, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      // top of range on header and one pairs, smallest legal zero mark and zero space
      '{ROW_WRITE, 12'h000, REG_HDR_MARK,   8'd255, 1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_HDR_SPACE,  8'd255, 1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_ZERO_MARK,  8'd1,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_ZERO_SPACE, 8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_ONE_MARK,   8'd255, 1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_WRITE, 12'h000, REG_ONE_SPACE,  8'd255, 1'b0, 1'b0, 8'd0,   8'd0},
      // out-of-range index must not touch any register
      '{ROW_WRITE, 12'h000, REG_PAST_END,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h3C3, REG_HDR_MARK,   8'd0,   1'b1, 1'b1, 8'd255, 8'd255},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b1, 1'b1, 8'd255, 8'd255},
      // limit of one with one idle frame already counted
      '{ROW_WRITE, 12'h000, REG_IDLE_LIMIT, 8'd1,   1'b0, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'h000, REG_HDR_MARK,   8'd0,   1'b1, 1'b0, 8'd0,   8'd0},
      '{ROW_TICK,  12'hC00, REG_HDR_MARK,   8'd0,   1'b0, 1'b0, 8'd0,   8'd0}
   };

   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  req_valid         = 1'b0;
   logic                  req_ready;
   logic [DATA_BITS-1:0]  req_joystick_bits = '0;
   logic                  rsp_valid;
   logic                  rsp_ready         = 1'b0;
   logic [LEN_W-1:0]      rsp_mark_length;
   logic [LEN_W-1:0]      rsp_space_length;
   logic                  rsp_frame_end;
   logic                  csr_valid         = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index         = '0;
   logic [LEN_W-1:0]      csr_data          = '0;

   // predictor state: register copy and the consecutive idle frame count
   logic [LEN_W-1:0] len_reg [NUM_REGS];
   logic [LEN_W-1:0] idle_run;

   pulse_pair_type pulse_q [$];
   pulse_pair_type head_pair;
   int          fail_count  = 0;
   int          quiet_cycles = 0;

   // sender burst shaping
   int unsigned burst_left = 0;
   int unsigned gap_max    = 5;

   // receiver stall pattern, refreshed when the stall age counter wraps
   logic [15:0] stall_mask = 16'hFFFF;
   logic [5:0]  stall_age  = '0;

   always #5 clock = ~clock;

   ir_joystick_frame_encoder_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_joystick_bits (req_joystick_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mark_length   (rsp_mark_length),
      .rsp_space_length  (rsp_space_length),
      .rsp_frame_end     (rsp_frame_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // a zero mark register still goes out as the shortest legal mark
   function automatic logic [LEN_W-1:0] mark_on_air(input logic [LEN_W-1:0] len);
      return (len == '0) ? LEN_W'(1) : len;
   endfunction

   // idle counting: saturates at the limit, cleared by any nonzero frame;
   // returns whether the frame goes out
   function automatic logic idle_gate(input logic [DATA_BITS-1:0] bits);
      if (bits == '0)
         idle_run = (idle_run < len_reg[REG_IDLE_LIMIT]) ? idle_run + 1'b1
                                                        : len_reg[REG_IDLE_LIMIT];
      else
         idle_run = '0;
      return idle_run < len_reg[REG_IDLE_LIMIT];
   endfunction

   // header, identifier as a zero bit, data msb first, inverted data msb first
   task automatic push_frame(input logic [DATA_BITS-1:0] bits,
                             input logic [LEN_W-1:0]     hdr_mark,
                             input logic [LEN_W-1:0]     hdr_space);
      logic [2*DATA_BITS-1:0] word;
      word = {bits, ~bits};
      pulse_q.push_back('{hdr_mark, hdr_space, 1'b0});
      pulse_q.push_back('{mark_on_air(len_reg[REG_ZERO_MARK]), len_reg[REG_ZERO_SPACE], 1'b0});
      for (int n = 2 * DATA_BITS - 1; n >= 0; n--) begin
         if (word[n])
            pulse_q.push_back('{mark_on_air(len_reg[REG_ONE_MARK]), len_reg[REG_ONE_SPACE],
                                n == 0});
         else
            pulse_q.push_back('{mark_on_air(len_reg[REG_ZERO_MARK]), len_reg[REG_ZERO_SPACE],
                                n == 0});
      end
   endtask

   // one frame tick; returns at the edge where it is taken
   task automatic send_tick(input logic [DATA_BITS-1:0] bits);
      int unsigned gap;
      if (csr_valid)
         csr_valid <= 1'b0;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, gap_max);
         burst_left = $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_joystick_bits <= bits;
      do @(posedge clock); while (!req_ready);
   endtask

   // leaves csr_valid high so back-to-back writes need no drop in between
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [LEN_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx < NUM_REGS)
         len_reg[idx] = val;
   endtask

   // wait for all outstanding beats, then for a possibly suppressed tick to retire
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pulse_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [LEN_W-1:0] pick_len();
      case ($urandom_range(0, 5))
         0:       return LEN_W'(0);
         1:       return LEN_W'(1);
         2:       return LEN_W'(255);
         default: return LEN_W'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly small limits so idle runs hit the ceiling, rarely zero or maximum
   function automatic logic [LEN_W-1:0] pick_limit();
      case ($urandom_range(0, 9))
         0:       return LEN_W'(0);
         1:       return LEN_W'(255);
         default: return LEN_W'($urandom_range(1, 6));
      endcase
   endfunction

   // receiver: rotate the stall mask each cycle, sometimes a stretch of no stalls
   always @(posedge clock) begin
      stall_age <= stall_age + 1'b1;
      if (stall_age == '1)
         stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      else
         stall_mask <= {stall_mask[0], stall_mask[15:1]};
      rsp_ready <= stall_mask[0];
   end

   // result checker: every accepted beat against the oldest expected pair
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pulse_q.size() == 0) begin
            $display("%0t: beat with nothing expected: mark %0d space %0d end %0b",
                     $time, rsp_mark_length, rsp_space_length, rsp_frame_end);
            fail_count++;
         end else begin
            head_pair = pulse_q.pop_front();
            if (rsp_mark_length !== head_pair.mark) begin
               $display("%0t: mark_length expected %0d actual %0d",
                        $time, head_pair.mark, rsp_mark_length);
               fail_count++;
            end
            if (rsp_space_length !== head_pair.space) begin
               $display("%0t: space_length expected %0d actual %0d",
                        $time, head_pair.space, rsp_space_length);
               fail_count++;
            end
            if (rsp_frame_end !== head_pair.last) begin
               $display("%0t: frame_end expected %0b actual %0b",
                        $time, head_pair.last, rsp_frame_end);
               fail_count++;
            end
         end
      end
   end

   // watchdog: too long without any beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_top: done, errors");
         $finish;
      end
   end

   initial begin
      stim_row_type         row;
      logic                 sent;
      logic [DATA_BITS-1:0] bits;
      int unsigned          ticks_sent;
      int unsigned          zero_run;
      int unsigned          n_ticks;

      for (int r = 0; r < NUM_REGS; r++)
         len_reg[r] = CFG_RESET[r];
      idle_run   = '0;
      ticks_sent = 0;
      zero_run   = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: walk the stimulus rows
      for (int i = 0; i < N_STIM; i++) begin
         row = STIM_ROWS[i];
         if (row.kind == ROW_WRITE) begin
            // registers change only once the block has gone idle
            if (i == 0 || STIM_ROWS[i-1].kind != ROW_WRITE)
               quiesce();
            write_reg(row.idx, row.val);
         end else begin
            send_tick(row.bits);
            sent = idle_gate(row.bits);
            if (row.pinned) begin
               if (row.sent)
                  push_frame(row.bits, row.hdr_mark, row.hdr_space);
            end else if (sent) begin
               push_frame(row.bits, mark_on_air(len_reg[REG_HDR_MARK]),
                          len_reg[REG_HDR_SPACE]);
            end
         end
      end

      // random part: phases of fresh register settings and tick streams
      while (ticks_sent < RAND_TICKS) begin
         quiesce();
         for (int r = REG_HDR_MARK; r <= REG_IDLE_LIMIT; r++)
            write_reg(CSR_IDX_W'(r), (r == REG_IDLE_LIMIT) ? pick_limit() : pick_len());
         if ($urandom_range(0, 3) == 0)
            write_reg(REG_PAST_END, LEN_W'($urandom_range(0, 255)));

         case ($urandom_range(0, 3))
            0:       gap_max = 0;
            1:       gap_max = 3;
            2:       gap_max = 12;
            default: gap_max = 40;
         endcase
         burst_left = 0;

         n_ticks = $urandom_range(8, 24);
         if (n_ticks > RAND_TICKS - ticks_sent)
            n_ticks = RAND_TICKS - ticks_sent;
         repeat (n_ticks) begin
            // idle runs of random length mixed with full and random button sets
            if (zero_run != 0) begin
               bits = '0;
               zero_run--;
            end else begin
               case ($urandom_range(0, 7))
                  0: begin
                     bits     = '0;
                     zero_run = $urandom_range(1, 8);
                  end
                  1:       bits = '1;
                  default: bits = DATA_BITS'($urandom_range(0, 4095));
               endcase
            end
            send_tick(bits);
            ticks_sent++;
            if (idle_gate(bits))
               push_frame(bits, mark_on_air(len_reg[REG_HDR_MARK]), len_reg[REG_HDR_SPACE]);
         end
      end

      // drain and let the last tick settle
      req_valid <= 1'b0;
      while (pulse_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/irjfe_pkg.sv
rtl/irjfe_sequencer.sv
rtl/ir_joystick_frame_encoder_unit.sv
dv/tb_top.sv
